[sv/ght_pkg.sv]
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and codes for the generational handle table: request and
// response beats, opcode and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int GEN_W        = 16;
    localparam int JOB_W        = 32;
    localparam int SEARCH_W     = 32;   // occupancy bits scanned per cycle
    localparam int SEARCH_BIT_W = 5;

    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_SHUT   = 3'd1;
    localparam logic [2:0] OP_REG    = 3'd2;
    localparam logic [2:0] OP_LOOKUP = 3'd3;
    localparam logic [2:0] OP_UNREG  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_ARG    = 3'd1;
    localparam logic [2:0] ST_NOT_INIT   = 3'd2;
    localparam logic [2:0] ST_ALREADY    = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] job_ref;
        logic [31:0] handle_index;
        logic [15:0] handle_generation;
    } ght_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_index;
        logic [15:0] slot_generation;
        logic [31:0] found_job_ref;
        logic [6:0]  live_count;
    } ght_rsp_t;

    typedef struct packed {
        logic       load_req;
        logic       init_tbl;
        logic       shut_tbl;
        logic       clr_step;
        logic       srch_start;
        logic       srch_step;
        logic       rd_handle;
        logic       rd_found;
        logic       do_reg;
        logic       do_unreg;
        logic       set_job;
        logic       load_out;
        logic [2:0] out_status;
    } ght_cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       job_zero;
        logic       handle_null;
        logic       active;
        logic       handle_ok;
        logic       gen_match;
        logic       free_found;
        logic       last_group;
        logic       clr_done;
        logic       out_free;
    } ght_stat_t;

endpackage

[sv/generational_handle_table.sv]
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot table handing out (index, generation) handles for job references.
// ----------------------------------------------------------------------------
// One request is handled at a time; each beat gives exactly one response
// beat through an output register. After accept the controller decodes the
// request. Shutdown and requests rejected at decode go straight to the
// response step. Lookup and unregister first read the slot memory and check
// the generation. Register scans the 32-slot occupancy groups in order up to
// the first free slot and then writes that slot; a full table responds once
// the last group is scanned. Init sweeps the generation memory one entry per
// cycle. The response step also waits while the previous response beat is
// still held off by rsp_ready. After reset the same sweep runs before the
// first request is taken.
module generational_handle_table #(
    parameter int SLOT_COUNT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ght_pkg::ght_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ght_pkg::ght_rsp_t rsp_data
);

    ght_pkg::ght_cmd_t  cmd;
    ght_pkg::ght_stat_t stat;

    ght_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ght_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef SYNTHESIS
    // failed operations report no handle and no job reference
    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != ght_pkg::ST_OK) |->
            (rsp_data.slot_generation == '0) && (rsp_data.found_job_ref == '0))
        else $error("failed response carries nonzero result fields");

    // a new response must never overwrite one not yet taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid || rsp_ready))
        else $error("response register overwritten");

    // single write port on the slot memory
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_reg && cmd.clr_step))
        else $error("slot memory written twice in one cycle");

    // one request in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request accepted while busy");
`endif

endmodule

[sv/ght_dp.sv]
// ----------------------------------------------------------------------------
// ght_dp
// Datapath: request register, occupancy bits, live count, slot memory
// (generation and job reference), free-slot search and response register.
// ----------------------------------------------------------------------------
module ght_dp #(
    parameter int SLOT_COUNT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ght_pkg::ght_req_t req_data,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output ght_pkg::ght_rsp_t rsp_data,
    input  ght_pkg::ght_cmd_t cmd,
    output ght_pkg::ght_stat_t stat
);

    localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int NUM_GRP = (SLOT_COUNT + ght_pkg::SEARCH_W - 1) / ght_pkg::SEARCH_W;
    localparam int GRP_W   = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
    localparam int PAD_W   = NUM_GRP * ght_pkg::SEARCH_W;
    localparam int WORD_W  = ght_pkg::GEN_W + ght_pkg::JOB_W;
    localparam int FULL_W  = GRP_W + ght_pkg::SEARCH_BIT_W;

    ght_pkg::ght_req_t req_reg;
    logic [SLOT_COUNT-1:0]       occ_reg;
    logic                        active_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [IDX_W-1:0]            clr_idx_reg;
    logic [GRP_W-1:0]            grp_reg;
    logic [IDX_W-1:0]            fnd_idx_reg;
    logic [WORD_W-1:0]           rd_word_reg;
    logic [IDX_W-1:0]            res_idx_reg;
    logic [ght_pkg::GEN_W-1:0]   res_gen_reg;
    logic [ght_pkg::JOB_W-1:0]   res_job_reg;
    ght_pkg::ght_rsp_t rsp_reg;
    logic                        rsp_valid_reg;

    logic [WORD_W-1:0] mem [SLOT_COUNT];

    logic [IDX_W-1:0]                 hidx;
    logic                             in_range;
    logic [PAD_W-1:0]                 occ_pad;
    logic [ght_pkg::SEARCH_W-1:0]     grp_bits;
    logic                             free_found;
    logic [ght_pkg::SEARCH_BIT_W-1:0] free_bit;
    logic [FULL_W-1:0]                fnd_full;
    logic [IDX_W-1:0]                 fnd_idx;
    logic [ght_pkg::GEN_W-1:0]        rd_gen;
    logic [ght_pkg::GEN_W-1:0]        new_gen;
    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [WORD_W-1:0]                wr_data;
    logic                             rd_en;
    logic [IDX_W-1:0]                 rd_addr;
    logic                             out_free;

    assign hidx     = req_reg.handle_index[IDX_W-1:0];
    assign in_range = req_reg.handle_index < 32'(SLOT_COUNT);

    // slots past the end of the table read as occupied so the search skips them
    always_comb
    begin
        occ_pad = '1;
        occ_pad[SLOT_COUNT-1:0] = occ_reg;
    end

    assign grp_bits = occ_pad[grp_reg * ght_pkg::SEARCH_W +: ght_pkg::SEARCH_W];

    always_comb
    begin
        free_found = 1'b0;
        free_bit   = '0;
        for (int i = ght_pkg::SEARCH_W - 1; i >= 0; i--)
        begin
            if (!grp_bits[i])
            begin
                free_found = 1'b1;
                free_bit   = ght_pkg::SEARCH_BIT_W'(i);
            end
        end
    end

    assign fnd_full = {grp_reg, free_bit};
    assign fnd_idx  = fnd_full[IDX_W-1:0];

    assign rd_gen = rd_word_reg[WORD_W-1:ght_pkg::JOB_W];

    // generation 0 is reserved for "never handed out"
    always_comb
    begin
        new_gen = rd_gen + 16'd1;
        if (new_gen == '0)
        begin
            new_gen = 16'd1;
        end
    end

    assign wr_en   = cmd.clr_step || cmd.do_reg;
    assign wr_addr = cmd.clr_step ? clr_idx_reg : fnd_idx_reg;
    assign wr_data = cmd.clr_step ? '0 : {new_gen, req_reg.job_ref};
    assign rd_en   = cmd.rd_handle || cmd.rd_found;
    assign rd_addr = cmd.rd_found ? fnd_idx : hidx;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            clr_idx_reg   <= '0;
            grp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_tbl)
            begin
                active_reg <= 1'b1;
                occ_reg    <= '0;
                cnt_reg    <= '0;
            end
            else if (cmd.shut_tbl)
            begin
                active_reg <= 1'b0;
                occ_reg    <= '0;
                cnt_reg    <= '0;
            end
            else if (cmd.do_reg)
            begin
                occ_reg[fnd_idx_reg] <= 1'b1;
                cnt_reg              <= cnt_reg + 1'b1;
            end
            else if (cmd.do_unreg)
            begin
                occ_reg[hidx] <= 1'b0;
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end

            if (cmd.clr_step)
            begin
                clr_idx_reg <= (clr_idx_reg == IDX_W'(SLOT_COUNT - 1)) ? '0 :
                               clr_idx_reg + 1'b1;
            end

            if (cmd.srch_start)
            begin
                grp_reg <= '0;
            end
            else if (cmd.srch_step)
            begin
                grp_reg <= grp_reg + 1'b1;
            end

            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg     <= req_data;
            res_idx_reg <= '0;
            res_gen_reg <= '0;
            res_job_reg <= '0;
        end
        else
        begin
            if (cmd.do_reg)
            begin
                res_idx_reg <= fnd_idx_reg;
                res_gen_reg <= new_gen;
            end
            if (cmd.set_job)
            begin
                res_job_reg <= rd_word_reg[ght_pkg::JOB_W-1:0];
            end
        end
        if (cmd.rd_found)
        begin
            fnd_idx_reg <= fnd_idx;
        end
        if (cmd.load_out)
        begin
            rsp_reg.status          <= cmd.out_status;
            rsp_reg.slot_index      <= 6'(res_idx_reg);
            rsp_reg.slot_generation <= res_gen_reg;
            rsp_reg.found_job_ref   <= res_job_reg;
            rsp_reg.live_count      <= 7'(cnt_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign stat.opcode      = req_reg.opcode;
    assign stat.job_zero    = (req_reg.job_ref == '0);
    assign stat.handle_null = (req_reg.handle_index == '0) && (req_reg.handle_generation == '0);
    assign stat.active      = active_reg;
    assign stat.handle_ok   = in_range && occ_reg[hidx];
    assign stat.gen_match   = (rd_gen == req_reg.handle_generation);
    assign stat.free_found  = free_found;
    assign stat.last_group  = (grp_reg == GRP_W'(NUM_GRP - 1));
    assign stat.clr_done    = (clr_idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign stat.out_free    = out_free;

endmodule

[sv/ght_ctrl.sv]
// ----------------------------------------------------------------------------
// ght_ctrl
// Controller: sequences one request at a time through decode, memory
// clear, free-slot search, slot read/check and response load.
// ----------------------------------------------------------------------------
module ght_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ght_pkg::ght_stat_t stat,
    output ght_pkg::ght_cmd_t  cmd
);

    localparam logic [2:0] S_RSTCLR  = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DECODE  = 3'd2;
    localparam logic [2:0] S_INITCLR = 3'd3;
    localparam logic [2:0] S_SEARCH  = 3'd4;
    localparam logic [2:0] S_REGWR   = 3'd5;
    localparam logic [2:0] S_CHECK   = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] st_reg;
    logic [2:0] st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RSTCLR;
            st_reg    <= ght_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        cmd            = '0;
        cmd.out_status = st_reg;
        case (state_reg)
            S_RSTCLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                st_next    = ght_pkg::ST_OK;
                case (stat.opcode)
                    ght_pkg::OP_INIT:
                    begin
                        if (stat.active)
                        begin
                            st_next = ght_pkg::ST_ALREADY;
                        end
                        else
                        begin
                            cmd.init_tbl = 1'b1;
                            state_next   = S_INITCLR;
                        end
                    end
                    ght_pkg::OP_SHUT:
                    begin
                        if (!stat.active)
                        begin
                            st_next = ght_pkg::ST_NOT_INIT;
                        end
                        else
                        begin
                            cmd.shut_tbl = 1'b1;
                        end
                    end
                    ght_pkg::OP_REG:
                    begin
                        if (stat.job_zero)
                        begin
                            st_next = ght_pkg::ST_BAD_ARG;
                        end
                        else if (!stat.active)
                        begin
                            st_next = ght_pkg::ST_NOT_INIT;
                        end
                        else
                        begin
                            cmd.srch_start = 1'b1;
                            state_next     = S_SEARCH;
                        end
                    end
                    ght_pkg::OP_LOOKUP, ght_pkg::OP_UNREG:
                    begin
                        if (stat.handle_null)
                        begin
                            st_next = ght_pkg::ST_BAD_ARG;
                        end
                        else if (!stat.active)
                        begin
                            st_next = ght_pkg::ST_NOT_INIT;
                        end
                        else if (!stat.handle_ok)
                        begin
                            st_next = ght_pkg::ST_BAD_HANDLE;
                        end
                        else
                        begin
                            cmd.rd_handle = 1'b1;
                            state_next    = S_CHECK;
                        end
                    end
                    default:
                    begin
                        st_next = ght_pkg::ST_BAD_ARG;
                    end
                endcase
            end
            S_INITCLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_SEARCH:
            begin
                if (stat.free_found)
                begin
                    cmd.rd_found = 1'b1;
                    state_next   = S_REGWR;
                end
                else if (stat.last_group)
                begin
                    st_next    = ght_pkg::ST_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                end
            end
            S_REGWR:
            begin
                cmd.do_reg = 1'b1;
                state_next = S_RESP;
            end
            S_CHECK:
            begin
                state_next = S_RESP;
                if (stat.gen_match)
                begin
                    if (stat.opcode == ght_pkg::OP_LOOKUP)
                    begin
                        cmd.set_job = 1'b1;
                    end
                    else
                    begin
                        cmd.do_unreg = 1'b1;
                    end
                end
                else
                begin
                    st_next = ght_pkg::ST_BAD_HANDLE;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[bench/ght_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ght_checker
// Passive scoreboard for the generational handle table. Every accepted
// request beat is run through a local model of the slot table; every
// accepted response beat is compared, field by field, with the oldest
// predicted response.
// ----------------------------------------------------------------------------
module ght_checker #(
    parameter int SLOT_COUNT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  ght_pkg::ght_req_t req_data,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  ght_pkg::ght_rsp_t rsp_data,
    output int                mismatches,
    output int                outstanding,
    output int                checked,
    output int                full_seen,
    output int                rejected_handles
);
    import ght_pkg::*;

    // local copy of the table
    logic        tbl_active;
    logic        slot_busy [SLOT_COUNT];
    logic [15:0] slot_gen  [SLOT_COUNT];
    logic [31:0] slot_job  [SLOT_COUNT];
    int unsigned live_slots;

    ght_rsp_t    expected_rsps [$];
    ght_rsp_t    exp_rsp;

    // Applies one request to the local table and returns the response it owes.
    function automatic ght_rsp_t apply_table_op(input ght_req_t r);
        ght_rsp_t    e;
        int          slot;
        logic [15:0] g;
        e        = '0;
        e.status = ST_OK;
        slot     = -1;
        case (r.opcode)
            OP_INIT:
            begin
                if (tbl_active)
                begin
                    e.status = ST_ALREADY;
                end
                else
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        slot_busy[i] = 1'b0;
                        slot_gen[i]  = '0;
                        slot_job[i]  = '0;
                    end
                    live_slots = 0;
                    tbl_active = 1'b1;
                end
            end
            OP_SHUT:
            begin
                if (!tbl_active)
                begin
                    e.status = ST_NOT_INIT;
                end
                else
                begin
                    // generations survive a shutdown
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        slot_busy[i] = 1'b0;
                        slot_job[i]  = '0;
                    end
                    live_slots = 0;
                    tbl_active = 1'b0;
                end
            end
            OP_REG:
            begin
                if (r.job_ref == '0)
                begin
                    e.status = ST_BAD_ARG;
                end
                else if (!tbl_active)
                begin
                    e.status = ST_NOT_INIT;
                end
                else
                begin
                    for (int i = SLOT_COUNT - 1; i >= 0; i--)
                    begin
                        if (!slot_busy[i])
                            slot = i;
                    end
                    if (slot < 0)
                    begin
                        e.status = ST_FULL;
                    end
                    else
                    begin
                        g = slot_gen[slot] + 16'd1;
                        if (g == '0)
                            g = 16'd1;     // zero is never a live generation
                        slot_gen[slot]    = g;
                        slot_busy[slot]   = 1'b1;
                        slot_job[slot]    = r.job_ref;
                        live_slots++;
                        e.slot_index      = 6'(slot);
                        e.slot_generation = g;
                    end
                end
            end
            OP_LOOKUP, OP_UNREG:
            begin
                if (r.handle_index == '0 && r.handle_generation == '0)
                begin
                    e.status = ST_BAD_ARG;
                end
                else if (!tbl_active)
                begin
                    e.status = ST_NOT_INIT;
                end
                else if (r.handle_index >= 32'(SLOT_COUNT))
                begin
                    e.status = ST_BAD_HANDLE;
                end
                else
                begin
                    slot = int'(r.handle_index);
                    if (!slot_busy[slot] || slot_gen[slot] != r.handle_generation)
                    begin
                        e.status = ST_BAD_HANDLE;
                    end
                    else if (r.opcode == OP_LOOKUP)
                    begin
                        e.found_job_ref = slot_job[slot];
                    end
                    else
                    begin
                        slot_busy[slot] = 1'b0;
                        slot_job[slot]  = '0;
                        if (live_slots > 0)
                            live_slots--;
                    end
                end
            end
            default:
            begin
                e.status = ST_BAD_ARG;
            end
        endcase
        e.live_count = live_slots[6:0];
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_active = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_busy[i] = 1'b0;
                slot_gen[i]  = '0;
                slot_job[i]  = '0;
            end
            live_slots = 0;
            expected_rsps.delete();
            mismatches       = 0;
            outstanding      = 0;
            checked          = 0;
            full_seen        = 0;
            rejected_handles = 0;
        end
        else
        begin
            // retire the response first: it always belongs to an older request
            if (rsp_valid && rsp_ready)
            begin
                checked++;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected response beat: st=%0d idx=%0d gen=%h job=%h live=%0d",
                                 $realtime, rsp_data.status, rsp_data.slot_index,
                                 rsp_data.slot_generation, rsp_data.found_job_ref,
                                 rsp_data.live_count);
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    if (exp_rsp.status == ST_FULL)
                        full_seen++;
                    if (exp_rsp.status == ST_BAD_HANDLE)
                        rejected_handles++;
                    if (rsp_data.status          !== exp_rsp.status          ||
                        rsp_data.slot_index      !== exp_rsp.slot_index      ||
                        rsp_data.slot_generation !== exp_rsp.slot_generation ||
                        rsp_data.found_job_ref   !== exp_rsp.found_job_ref   ||
                        rsp_data.live_count      !== exp_rsp.live_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] response mismatch on beat %0d", $realtime, checked);
                            $display("    exp: st=%0d idx=%0d gen=%h job=%h live=%0d",
                                     exp_rsp.status, exp_rsp.slot_index,
                                     exp_rsp.slot_generation, exp_rsp.found_job_ref,
                                     exp_rsp.live_count);
                            $display("    got: st=%0d idx=%0d gen=%h job=%h live=%0d",
                                     rsp_data.status, rsp_data.slot_index,
                                     rsp_data.slot_generation, rsp_data.found_job_ref,
                                     rsp_data.live_count);
                        end
                    end
                end
            end
            if (req_valid && req_ready)
                expected_rsps.push_back(apply_table_op(req_data));
            outstanding = expected_rsps.size();
        end
    end

endmodule

[bench/generational_handle_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generational_handle_table_tb
// Stimulus and verdict for the generational handle table. A directed pass
// walks the status codes and fills the table, a register/release loop on
// slot 0 walks its generation up, then random traffic mixes valid, stale,
// out-of-range and null handles under bursty input and a stalling response
// side. Checking is done by ght_checker.
// ----------------------------------------------------------------------------
module generational_handle_table_tb;
    import ght_pkg::*;

    localparam int         SLOTS        = 64;
    localparam int         RANDOM_ITEMS = 1400;
    localparam int         SLOT0_PAIRS  = 100;
    localparam int         CYCLE_LIMIT  = 400_000;
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    typedef struct packed {
        logic [31:0] idx;
        logic [15:0] gen;
    } handle_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;
    typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_mode_e;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    ght_req_t req_data  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    ght_rsp_t rsp_data;

    int mismatches, outstanding, checked, full_seen, rejected_handles;

    // stimulus control
    bit       idle_en   = 1'b1;
    bit       random_on = 1'b0;
    int       burst_left = 0;
    int       reqs_sent  = 0;
    int       cycle_count = 0;
    handle_t  known_handles [$];

    // receiver state
    rx_mode_e rx_mode      = RX_OPEN;
    int       stretch_left = 0;
    int       holdoff_left = 0;
    int       since_hold   = 0;

    generational_handle_table #(.SLOT_COUNT(SLOTS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    ght_checker #(.SLOT_COUNT(SLOTS)) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req_data         (req_data),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp_data         (rsp_data),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .checked          (checked),
        .full_seen        (full_seen),
        .rejected_handles (rejected_handles)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still owed",
                     cycle_count, outstanding);
            $display("** generational_handle_table: FAILED **");
            $finish;
        end
    end

    // Response side: stretches of open, coin-flip and sparse ready, plus a
    // periodic long hold-off so the request side backs up.
    always @(posedge clk)
    begin
        if (!idle_en)
        begin
            rsp_ready <= 1'b1;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (random_on)
                since_hold++;
            if (since_hold >= 3000)
            begin
                since_hold   = 0;
                holdoff_left = 400;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    rx_mode      = rx_mode_e'($urandom_range(0, 2));
                    stretch_left = $urandom_range(16, 160);
                end
                stretch_left--;
                case (rx_mode)
                    RX_OPEN:  rsp_ready <= 1'b1;
                    RX_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
                    default:  rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Harvest handles from successful registers. Both valid and ready are
    // stable here, so the beat is taken at the coming rising edge.
    always @(negedge clk)
    begin
        if (rsp_valid && rsp_ready && rsp_data.status == ST_OK &&
            rsp_data.slot_generation != '0)
        begin
            known_handles.push_back('{idx: 32'(rsp_data.slot_index),
                                      gen: rsp_data.slot_generation});
            if (known_handles.size() > 80)
                void'(known_handles.pop_front());
        end
    end

    function automatic ght_req_t mk_req(input logic [2:0]  op,
                                        input logic [31:0] job,
                                        input logic [31:0] idx,
                                        input logic [15:0] gen);
        ght_req_t r;
        r.opcode            = op;
        r.job_ref           = job;
        r.handle_index      = idx;
        r.handle_generation = gen;
        return r;
    endfunction

    // One request beat, with burst/gap pacing on the valid side.
    task automatic drive_req(input ght_req_t r);
        int gap;
        if (idle_en && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left != 0)
            burst_left--;
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        reqs_sent++;
    endtask

    initial
    begin
        int          reg_pct   [3];
        int          unreg_pct [3];
        mix_mode_e   mix;
        bit          tbl_on;
        logic [15:0] g;
        logic [31:0] job;

        reg_pct   = '{40, 75, 15};
        unreg_pct = '{25, 8, 50};
        mix       = MIX_BALANCED;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: status codes before and after init ----
        drive_req(mk_req(OP_LOOKUP, 32'h0000_0007, 32'd1, 16'd1));       // not initialized
        drive_req(mk_req(OP_REG, 32'h0, 32'd0, 16'd0));                  // null job beats inactive
        drive_req(mk_req(OP_REG, 32'h0000_0001, 32'd0, 16'd0));          // not initialized
        drive_req(mk_req(OP_SHUT, 32'h0, 32'd0, 16'd0));                 // not initialized
        drive_req(mk_req(OP_LOOKUP, 32'h0, 32'd0, 16'd0));               // null handle, inactive
        drive_req(mk_req(OP_INIT, 32'h0, 32'd0, 16'd0));
        drive_req(mk_req(OP_INIT, 32'h0, 32'd0, 16'd0));                 // already active
        drive_req(mk_req(OP_REG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        drive_req(mk_req(OP_REG, 32'h0000_0001, 32'd0, 16'd0));
        drive_req(mk_req(OP_LOOKUP, 32'h0, 32'd0, 16'd1));
        drive_req(mk_req(OP_LOOKUP, 32'h0, 32'd0, 16'd2));               // wrong generation
        drive_req(mk_req(OP_LOOKUP, 32'h0, 32'hFFFF_FFFF, 16'hFFFF));    // far out of range
        drive_req(mk_req(OP_LOOKUP, 32'h0, 32'(SLOTS), 16'd1));          // one past the end
        drive_req(mk_req(OP_UNREG, 32'h0, 32'd0, 16'd0));                // null handle
        drive_req(mk_req(OP_UNREG, 32'h0, 32'd0, 16'd1));
        drive_req(mk_req(OP_UNREG, 32'h0, 32'd0, 16'd1));                // slot already free
        drive_req(mk_req(OP_LOOKUP, 32'h0, 32'd0, 16'd1));
        drive_req(mk_req(OP_REG, 32'hA5A5_5A5A, 32'd0, 16'd0));          // slot 0 again, gen 2
        drive_req(mk_req(OP_LAST_UNUSED, 32'h0, 32'd0, 16'd0));
        drive_req(mk_req(OP_FIRST_UNUSED, 32'h1, 32'd1, 16'd1));
        drive_req(mk_req(OP_SHUT, 32'h0, 32'd0, 16'd0));
        drive_req(mk_req(OP_LOOKUP, 32'h0, 32'd1, 16'd1));               // inactive after shutdown
        drive_req(mk_req(OP_INIT, 32'h0, 32'd0, 16'd0));
        // fill every slot, then one more for table full
        for (int i = 0; i <= SLOTS; i++)
        begin
            job = $urandom;
            drive_req(mk_req(OP_REG, (job == '0) ? 32'h1 : job, $urandom, 16'($urandom)));
        end
        drive_req(mk_req(OP_UNREG, 32'h0, 32'(SLOTS - 1), 16'd1));       // top slot
        drive_req(mk_req(OP_REG, 32'h0000_0042, 32'd0, 16'd0));          // lands in top slot

        // ---- slot 0 register/release loop, generation walks up ----
        idle_en = 1'b0;
        drive_req(mk_req(OP_SHUT, 32'h0, 32'd0, 16'd0));
        drive_req(mk_req(OP_INIT, 32'h0, 32'd0, 16'd0));
        g = '0;
        for (int i = 0; i < SLOT0_PAIRS; i++)
        begin
            g = g + 16'd1;
            if (g == '0)
                g = 16'd1;
            drive_req(mk_req(OP_REG, $urandom | 32'h1, $urandom, 16'($urandom)));
            drive_req(mk_req(OP_UNREG, $urandom, 32'd0, g));
        end
        idle_en = 1'b1;
        known_handles.delete();

        // ---- random traffic ----
        random_on = 1'b1;
        tbl_on    = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin : rand_item
            ght_req_t r;
            int       roll;
            int       pick;
            int       k;
            if (n % 64 == 0)
                mix = mix_mode_e'($urandom_range(0, 2));
            roll = $urandom_range(0, 999);
            r    = mk_req(OP_LOOKUP, $urandom, $urandom, 16'($urandom));
            if (!tbl_on && roll < 400)
            begin
                r.opcode = OP_INIT;
            end
            else if (roll < 8)
            begin
                r.opcode = OP_INIT;
            end
            else if (roll < ((mix == MIX_FILL) ? 10 : 22))
            begin
                r.opcode = OP_SHUT;
            end
            else if (roll < 40)
            begin
                r.opcode = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < reg_pct[mix])
                begin
                    r.opcode = OP_REG;
                    if ($urandom_range(0, 19) == 0)
                        r.job_ref = '0;
                    else if (r.job_ref == '0)
                        r.job_ref = '1;
                end
                else
                begin
                    r.opcode = (pick < reg_pct[mix] + unreg_pct[mix]) ? OP_UNREG : OP_LOOKUP;
                    pick     = $urandom_range(0, 99);
                    if (known_handles.size() != 0 && pick < 80)
                    begin
                        k                   = $urandom_range(0, known_handles.size() - 1);
                        r.handle_index      = known_handles[k].idx;
                        r.handle_generation = known_handles[k].gen;
                        if (r.opcode == OP_UNREG)
                            known_handles.delete(k);
                        if ($urandom_range(0, 9) == 0)
                            r.handle_generation ^= 16'($urandom_range(1, 65535));
                    end
                    else if (pick < 86)
                    begin
                        r.handle_index      = '0;
                        r.handle_generation = '0;
                    end
                    else if (pick < 93)
                    begin
                        r.handle_index      = 32'($urandom_range(0, SLOTS - 1));
                        r.handle_generation = 16'($urandom_range(0, 3));
                    end
                    else if (r.handle_index < 32'(SLOTS))
                    begin
                        r.handle_index = r.handle_index + 32'(SLOTS);
                    end
                end
            end
            if (r.opcode == OP_INIT || r.opcode == OP_SHUT)
            begin
                tbl_on = (r.opcode == OP_INIT);
                known_handles.delete();
            end
            drive_req(r);
        end
        req_valid <= 1'b0;

        // drain, then give the block time to show any stray beat
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SLOTS + 16) @(posedge clk);

        $display("%0d requests driven, including %0d slot-0 register/release pairs",
                 reqs_sent, SLOT0_PAIRS);
        $display("%0d responses checked, %0d table-full, %0d rejected handles, %0d mismatches",
                 checked, full_seen, rejected_handles, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("** generational_handle_table: PASSED **");
        else
            $display("** generational_handle_table: FAILED **");
        $finish;
    end

endmodule

[files.f]
sv/ght_pkg.sv
sv/ght_dp.sv
sv/ght_ctrl.sv
sv/generational_handle_table.sv
bench/ght_checker.sv
bench/generational_handle_table_tb.sv
